/* hw/rtl/bwbg_pkg.sv */
// Package for the Bezier wire bead generator: bead limits, widths, fixed-point constants.
// No dependencies.
package bwbg_pkg;
	localparam int unsigned MaxBeads    = 48;
	localparam int unsigned MinBeads    = 10;
	localparam int unsigned BeadW       = 6;
	localparam logic [20:0] SpanMinQ    = 21'd2621;
	localparam logic [15:0] LiftGainQ   = 16'd15729;
	localparam logic [17:0] LiftLoQ     = 18'd18350;
	localparam logic [17:0] LiftHiQ     = 18'd121242;
	localparam logic [20:0] BeadStepQ   = 21'd11796;
	localparam logic [20:0] SpanSat     = 21'd1048576;
	localparam logic [32:0] DeltaLimit  = 33'd1048576;
endpackage

/* hw/rtl/bwbg_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing but its ports.
module bwbg_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [41:0] radicand,
	output logic        done,
	output logic [20:0] root
);
	logic [41:0] rem_q;
	logic [41:0] res_q;
	logic [41:0] bit_q;
	logic        run_q;
	logic [42:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign root  = res_q[20:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				rem_q <= radicand;
				res_q <= '0;
				bit_q <= 42'h1 << 40;
				run_q <= 1'b1;
			end else if (run_q) begin
				// one trial subtract per step
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= rem_q - trial[41:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
endmodule

/* hw/rtl/bezier_wire_bead_generator.sv */
// Top level of the Bezier wire bead generator.
// Depends on bwbg_pkg and bwbg_isqrt.
//
// Give start with two endpoints in signed Q16.16. Busy rises at the accepting
// edge and falls at the edge that puts the last bead word out, so a new word
// may be taken while that last word is on the ports. The span is formed in
// order: the sum of squares, then the square root unit (a load, 21 steps of
// one bit each, and a pickup of the root). A short span (below 0.04) gives no
// word and ends there. Otherwise the lift is formed and the bead count takes
// floor(span / 0.18) subtract steps, stopped at the upper clamp. Each bead
// then runs a restoring divide of i*65536 by the bead count (22 steps), five
// steps on the single shared 34x34 multiplier (x, y and z steps along the
// delta, u*t, and the lift term) and a step to show the word. Each bead
// word is on the result ports for one cycle under strobe and the receiver
// cannot stall it; last_bead marks the word for t = 1.
module bezier_wire_bead_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] from_x,
	input  logic signed [31:0] from_y,
	input  logic signed [31:0] from_z,
	input  logic signed [31:0] to_x,
	input  logic signed [31:0] to_y,
	input  logic signed [31:0] to_z,
	output logic               strobe,
	output logic [5:0]         bead_index,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               last_bead
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_LIFT, ST_CNT, ST_TDIV,
		ST_MX, ST_MY, ST_MZ, ST_UT, ST_BUMP, ST_EMIT
	} state_t;

	state_t             state_q;
	logic signed [31:0] p0_q [3];
	logic signed [32:0] d_q  [3];
	logic [41:0]        sum_q;
	logic [1:0]         ax_q;
	logic               big_q;
	logic [20:0]        span_q;
	logic [17:0]        lift_q;
	logic [5:0]         beads_q;
	logic [5:0]         idx_q;
	logic [16:0]        t_q;
	logic [22:0]        drem_q;
	logic [4:0]         dcnt_q;
	logic signed [33:0] res_q [3];
	logic [33:0]        ut_q;
	logic               sq_go_q;
	logic               sq_done;
	logic [20:0]        sq_root;

	// shared multiplier
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [67:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic signed [32:0] dsel;
	assign dsel = d_q[ax_q];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = 34'(dsel);
				mul_b = 34'(dsel);
			end
			ST_LIFT: begin
				mul_a = $signed({13'd0, span_q});
				mul_b = $signed({18'd0, bwbg_pkg::LiftGainQ});
			end
			ST_MX, ST_MY, ST_MZ: begin
				mul_a = $signed({17'd0, t_q});
				mul_b = 34'(dsel);
			end
			ST_UT: begin
				mul_a = $signed({17'd0, t_q});
				mul_b = $signed({17'd0, 17'(17'd65536 - t_q)});
			end
			ST_BUMP: begin
				mul_a = $signed({1'b0, ut_q[32:0]});
				mul_b = $signed({16'd0, lift_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic signed [33:0] rnd16;
	assign rnd16 = 34'(($signed(mul_p) + 68'sd32768) >>> 16);
	// bump = floor((2*ut*lift + 2^31) / 2^32) = floor((ut*lift + 2^30)/2^31)
	logic [33:0] bump;
	assign bump = 34'((mul_p + 68'sd1073741824) >>> 31);

	logic [33:0] lift_raw;
	assign lift_raw = 34'(mul_p >>> 16);

	bwbg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go_q),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh07FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -34'sh080000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
			sq_go_q <= 1'b0;
		end else begin
			strobe  <= 1'b0;
			sq_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						p0_q[0] <= from_x;
						p0_q[1] <= from_y;
						p0_q[2] <= from_z;
						d_q[0]  <= 33'(to_x) - 33'(from_x);
						d_q[1]  <= 33'(to_y) - 33'(from_y);
						d_q[2]  <= 33'(to_z) - 33'(from_z);
						sum_q   <= '0;
						ax_q    <= 2'd0;
						big_q   <= 1'b0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					// flag a large delta; squares then cannot matter
					if (dsel >= $signed(bwbg_pkg::DeltaLimit) ||
						dsel <= -$signed(bwbg_pkg::DeltaLimit))
						big_q <= 1'b1;
					else
						sum_q <= sum_q + mul_p[41:0];
					if (ax_q == 2'd2) begin
						sq_go_q <= 1'b1;
						state_q <= ST_SQRT;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						span_q  <= big_q ? bwbg_pkg::SpanSat : sq_root;
						state_q <= (big_q || sq_root >= bwbg_pkg::SpanMinQ) ?
							ST_LIFT : ST_IDLE;
					end
				end
				ST_LIFT: begin
					if (lift_raw < 34'(bwbg_pkg::LiftLoQ)) lift_q <= bwbg_pkg::LiftLoQ;
					else if (lift_raw > 34'(bwbg_pkg::LiftHiQ)) lift_q <= bwbg_pkg::LiftHiQ;
					else lift_q <= lift_raw[17:0];
					drem_q  <= {2'd0, span_q};
					beads_q <= '0;
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					// repeated subtraction; stops at the upper clamp
					if (drem_q[20:0] >= bwbg_pkg::BeadStepQ &&
						beads_q < 6'(bwbg_pkg::MaxBeads)) begin
						drem_q  <= drem_q - {2'd0, bwbg_pkg::BeadStepQ};
						beads_q <= beads_q + 6'd1;
					end else begin
						if (beads_q < 6'(bwbg_pkg::MinBeads))
							beads_q <= 6'(bwbg_pkg::MinBeads);
						idx_q   <= '0;
						drem_q  <= '0;
						t_q     <= '0;
						dcnt_q  <= 5'd0;
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					// restoring divide of idx*65536 by beads, one quotient bit a cycle
					logic [21:0] num;
					logic [22:0] sh;
					num = {idx_q, 16'd0};
					sh = {drem_q[21:0], num[5'd21 - dcnt_q]};
					if (sh[22:0] >= {17'd0, beads_q}) begin
						drem_q <= sh - {17'd0, beads_q};
						t_q    <= {t_q[15:0], 1'b1};
					end else begin
						drem_q <= sh;
						t_q    <= {t_q[15:0], 1'b0};
					end
					if (dcnt_q == 5'd21) begin
						ax_q    <= 2'd0;
						state_q <= ST_MX;
					end else begin
						dcnt_q <= dcnt_q + 5'd1;
					end
				end
				ST_MX: begin
					res_q[0] <= 34'(p0_q[0]) + rnd16;
					ax_q     <= 2'd1;
					state_q  <= ST_MY;
				end
				ST_MY: begin
					res_q[1] <= 34'(p0_q[1]) + rnd16;
					ax_q     <= 2'd2;
					state_q  <= ST_MZ;
				end
				ST_MZ: begin
					res_q[2] <= 34'(p0_q[2]) + rnd16;
					state_q  <= ST_UT;
				end
				ST_UT: begin
					ut_q    <= mul_p[33:0];
					state_q <= ST_BUMP;
				end
				ST_BUMP: begin
					res_q[1] <= res_q[1] + $signed(bump);
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe     <= 1'b1;
					bead_index <= idx_q;
					point_x    <= sat32(res_q[0]);
					point_y    <= sat32(res_q[1]);
					point_z    <= sat32(res_q[2]);
					last_bead  <= (idx_q == beads_q);
					if (idx_q == beads_q) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 6'd1;
						drem_q  <= '0;
						t_q     <= '0;
						dcnt_q  <= 5'd0;
						state_q <= ST_TDIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the Bezier wire bead generator: directed curves, then random ones.
// Depends on bwbg_pkg and the bezier_wire_bead_generator RTL.
`timescale 1ns / 1ps

module tb_top;
	localparam int CycleLimit = 1000000;
	localparam int RandomCurves = 100;
	// unknown bead count in the stimulus table: leave it to the predictor
	localparam int AnyCount = -1;

	typedef struct {
		logic signed [31:0] fx, fy, fz, tx, ty, tz;
		int                 words; // bead words expected, or AnyCount
	} curve_t;

	typedef struct {
		logic [5:0]         idx;
		logic signed [31:0] x, y, z;
		logic               last;
	} bead_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] from_x = '0, from_y = '0, from_z = '0;
	logic signed [31:0] to_x = '0, to_y = '0, to_z = '0;
	logic               strobe;
	logic [5:0]         bead_index;
	logic signed [31:0] point_x, point_y, point_z;
	logic               last_bead;

	bead_t   bead_fifo[$];
	curve_t  dir_curves[$];
	int      mismatches = 0;
	int      beads_seen = 0;
	int      curves_sent = 0;
	int      short_spans = 0;
	longint  cycles = 0;

	bezier_wire_bead_generator DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %0s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
		mismatches++;
	endtask

	// Append one row to the directed stimulus table.
	task automatic add_row(input curve_t c);
		dir_curves.insert(dir_curves.size(), c);
	endtask

	// Integer square root, one result bit per pass.
	function automatic longint unsigned span_root(input longint unsigned v);
		longint unsigned res, bit_q;
		res = 0;
		bit_q = 64'd1 << 62;
		while (bit_q > v)
			bit_q >>= 2;
		while (bit_q != 0) begin
			if (v >= res + bit_q) begin
				v -= res + bit_q;
				res = (res >> 1) + bit_q;
			end else begin
				res >>= 1;
			end
			bit_q >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Work out every bead of one curve and queue it; return the bead word count.
	function automatic int queue_curve_beads(input curve_t c);
		longint p0[3], d[3];
		longint unsigned span, sum;
		longint lift, nbeads, t, u, bump, v;
		bit big;
		bead_t b;
		p0[0] = c.fx; p0[1] = c.fy; p0[2] = c.fz;
		d[0] = longint'(c.tx) - p0[0];
		d[1] = longint'(c.ty) - p0[1];
		d[2] = longint'(c.tz) - p0[2];
		big = 1'b0;
		sum = 0;
		for (int ax = 0; ax < 3; ax++) begin
			if (d[ax] >= longint'(bwbg_pkg::DeltaLimit) ||
				-d[ax] >= longint'(bwbg_pkg::DeltaLimit))
				big = 1'b1;
			sum += longint'(d[ax] * d[ax]);
		end
		span = big ? longint'(bwbg_pkg::SpanSat) : span_root(sum);
		if (span < longint'(bwbg_pkg::SpanMinQ))
			return 0;
		lift = longint'((span * longint'(bwbg_pkg::LiftGainQ)) >> 16);
		if (lift < longint'(bwbg_pkg::LiftLoQ)) lift = bwbg_pkg::LiftLoQ;
		if (lift > longint'(bwbg_pkg::LiftHiQ)) lift = bwbg_pkg::LiftHiQ;
		nbeads = longint'(span / longint'(bwbg_pkg::BeadStepQ));
		if (nbeads < bwbg_pkg::MinBeads) nbeads = bwbg_pkg::MinBeads;
		if (nbeads > bwbg_pkg::MaxBeads) nbeads = bwbg_pkg::MaxBeads;
		for (longint i = 0; i <= nbeads; i++) begin
			t = (i * 65536) / nbeads;
			u = 65536 - t;
			bump = (2 * u * t * lift + (64'sd1 <<< 31)) >>> 32;
			b.idx = i[5:0];
			v = p0[0] + ((t * d[0] + 32768) >>> 16);
			b.x = sat32(v);
			v = p0[1] + ((t * d[1] + 32768) >>> 16) + bump;
			b.y = sat32(v);
			v = p0[2] + ((t * d[2] + 32768) >>> 16);
			b.z = sat32(v);
			b.last = (i == nbeads);
			bead_fifo.insert(bead_fifo.size(), b);
		end
		return int'(nbeads) + 1;
	endfunction

	// Half the time no gap, most others short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// Present one curve and hold start until the word is taken, then queue its beads.
	task automatic send_curve(input curve_t c, input int gap);
		int n;
		from_x <= c.fx; from_y <= c.fy; from_z <= c.fz;
		to_x <= c.tx; to_y <= c.ty; to_z <= c.tz;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		n = queue_curve_beads(c);
		if (c.words != AnyCount && n != c.words)
			report("bead count of table row", n, c.words);
		if (n == 0)
			short_spans++;
		curves_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Build a random curve: half well-formed spans, some tiny, the rest raw noise.
	function automatic curve_t random_curve();
		curve_t c;
		int kind;
		logic signed [31:0] dx, dy, dz;
		c.fx = $urandom; c.fy = $urandom; c.fz = $urandom;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			dx = $signed($urandom_range(0, 1200000)) - 600000;
			dy = $signed($urandom_range(0, 1200000)) - 600000;
			dz = $signed($urandom_range(0, 1200000)) - 600000;
		end else if (kind < 7) begin
			dx = $signed($urandom_range(0, 6000)) - 3000;
			dy = $signed($urandom_range(0, 6000)) - 3000;
			dz = $signed($urandom_range(0, 6000)) - 3000;
		end else begin
			dx = $urandom; dy = $urandom; dz = $urandom;
		end
		// keep the start well inside range on well-formed and tiny curves so wrap stays rare
		if (kind < 7) begin
			c.fx = $signed(c.fx) >>> 2;
			c.fy = $signed(c.fy) >>> 2;
			c.fz = $signed(c.fz) >>> 2;
		end
		c.tx = c.fx + dx; c.ty = c.fy + dy; c.tz = c.fz + dz;
		c.words = AnyCount;
		return c;
	endfunction

	// Check every strobed bead word against the oldest queued bead.
	always @(posedge clk) begin
		bead_t e;
		if (arst_n && strobe) begin
			beads_seen++;
			if (bead_fifo.size() == 0) begin
				report("unexpected bead word, index", bead_index, -1);
			end else begin
				e = bead_fifo.pop_front();
				if (bead_index !== e.idx) report("bead_index", bead_index, e.idx);
				if (point_x !== e.x) report("point_x", point_x, e.x);
				if (point_y !== e.y) report("point_y", point_y, e.y);
				if (point_z !== e.z) report("point_z", point_z, e.z);
				if (last_bead !== e.last) report("last_bead", last_bead, e.last);
			end
		end
	end

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		curve_t c;
		// zero span and below the minimum: no words
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0});
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd2620, 32'sd0, 32'sd0, 0});
		add_row('{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 0});
		// span just at the minimum: bead count on its lower clamp
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd2621, 32'sd0, 32'sd0, 11});
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd2621, 32'sd0, 11});
		// bead count exactly at its upper clamp, below saturation
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd566208, 32'sd0, 32'sd0, 49});
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd566208, 49});
		// span between the clamps
		add_row('{32'sd65536, -32'sd65536, 32'sd1000, 32'sd200000,
			32'sd50000, -32'sd90000, AnyCount});
		// large span: delta of exactly 16.0 saturates
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd1048576, 32'sd0, 32'sd0, 49});
		add_row('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1048576, 49});
		// full-range endpoints on every axis
		add_row('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 49});
		add_row('{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 49});
		// y at the top with a lift: point_y saturates mid-curve
		add_row('{32'sd0, 32'sh7fffffff, 32'sd0, 32'sd2000000,
			32'sh7fffffff, 32'sd0, 49});
		add_row('{-32'sd5, 32'sh7ffff000, 32'sd7, 32'sd300000,
			32'sh7ffff000, 32'sd7, AnyCount});
		// mixed-sign deltas near the short-span edge
		add_row('{32'sd1500, -32'sd1500, 32'sd1500, -32'sd1, 32'sd1, -32'sd1, AnyCount});

		// hold reset, then release it between edges
		repeat (4) @(posedge clk);
		#2 arst_n = 1'b1;
		@(posedge clk);

		foreach (dir_curves[k])
			send_curve(dir_curves[k], (k % 3 == 0) ? 0 : pick_gap());

		for (int n = 0; n < RandomCurves; n++) begin
			c = random_curve();
			send_curve(c, pick_gap());
			// halfway through, hold off new words until every queued bead has drained
			if (n == RandomCurves / 2) begin
				start <= 1'b0;
				wait (bead_fifo.size() == 0);
				@(posedge clk);
			end
		end
		start <= 1'b0;

		wait (bead_fifo.size() == 0);
		repeat (400) @(posedge clk);

		$display("Covered %0d curves (%0d short spans with no beads), %0d bead words checked.",
			curves_sent, short_spans, beads_seen);
		$display("Directed extremes, clamps and saturation, then random spans of all sizes.");
		if (mismatches == 0 && bead_fifo.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Mismatches: %0d, beads still owed: %0d", mismatches, bead_fifo.size());
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
